[rtl/fcap_pkg.sv]
// Shared types, character codes and helper functions for the framed angle parser.
// Used by fcap_step, by the top level xor_checked_angle_frame_parser and by the testbench.
// Depends on nothing else.
package fcap_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int JOINTS_DEF  = 3;
    localparam int ANGLE_SLOTS = 3;

    localparam logic [1:0] ST_IN_PROGRESS = 2'd0;
    localparam logic [1:0] ST_SUCCESS     = 2'd1;
    localparam logic [1:0] ST_FORMAT      = 2'd2;
    localparam logic [1:0] ST_CHECKSUM    = 2'd3;

    localparam logic [1:0] MODE_WAIT_START = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD    = 2'd1;
    localparam logic [1:0] MODE_CHECK      = 2'd2;
    localparam logic [1:0] MODE_WAIT_EOL   = 2'd3;

    localparam logic [2:0] HDR_NONE   = 3'd0;
    localparam logic [2:0] HDR_D      = 3'd1;
    localparam logic [2:0] HDR_DR     = 3'd2;
    localparam logic [2:0] HDR_DRV    = 3'd3;
    localparam logic [2:0] HDR_OK     = 3'd4;
    localparam logic [2:0] HDR_REJECT = 3'd5;

    localparam logic [1:0] PH_BETWEEN = 2'd0;
    localparam logic [1:0] PH_SPACE   = 2'd1;
    localparam logic [1:0] PH_DIGITS  = 2'd2;
    localparam logic [1:0] PH_IGNORE  = 2'd3;

    localparam logic [7:0] CH_START = 8'h40;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EOL   = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [7:0] ANGLE_MAX   = 8'd180;
    localparam logic [7:0] ANGLE_SAT   = 8'd181;
    localparam logic [7:0] ANGLE_RESET = 8'd90;

    typedef logic [ANGLE_SLOTS-1:0][7:0] t_angles;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] xor_acc;
        logic [4:0] first_nibble;
        logic       check_count;
        logic       text_ended;
        logic [2:0] header;
        logic [1:0] joints_done;
        logic [1:0] phase;
        logic       negative;
        logic [7:0] value;
    } t_frame_state;

    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = 5'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = 5'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = 5'(b - 8'h57);
        end else begin
            r = 5'h10;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
               (b == 8'h0C) || (b == 8'h0D);
    endfunction

endpackage

[rtl/fcap_step.sv]
// Next-state logic of the parser: takes one byte and the current frame state and
// returns the updated state, angle stores and status. Depends on fcap_pkg.
module fcap_step
    import fcap_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int JOINTS  = JOINTS_DEF,
    localparam int CW     = $clog2(MAX_LEN)
) (
    input  logic [7:0]    i_byte,
    input  t_frame_state  i_state,
    input  logic [CW-1:0] i_count,
    input  t_angles       i_pending,
    input  t_angles       i_committed,
    output t_frame_state  o_state,
    output logic [CW-1:0] o_count,
    output t_angles       o_pending,
    output t_angles       o_committed,
    output logic [1:0]    o_status
);

    t_frame_state s;
    logic [1:0]   ph;
    logic [10:0]  grown;
    logic [4:0]   lo;
    logic [7:0]   cur_angle;
    logic [2:0]   n_done;
    logic         te;
    logic         fin_ok;

    always_comb begin
        s           = i_state;
        o_count     = i_count;
        o_pending   = i_pending;
        o_committed = i_committed;
        o_status    = ST_IN_PROGRESS;
        ph          = PH_BETWEEN;
        grown       = '0;
        lo          = nibble_of(i_byte);
        cur_angle   = i_state.negative ? 8'd0 :
                      (i_state.value > ANGLE_MAX ? ANGLE_MAX : i_state.value);
        n_done      = {1'b0, i_state.joints_done};
        te          = 1'b0;
        fin_ok      = 1'b0;

        unique case (i_state.mode)
            MODE_WAIT_START: begin
                if (i_byte == CH_START) begin
                    s         = '0;
                    s.mode    = MODE_PAYLOAD;
                    o_count   = '0;
                end
            end
            MODE_PAYLOAD: begin
                if (i_byte == CH_STAR) begin
                    s.check_count = 1'b0;
                    s.mode        = MODE_CHECK;
                end else if (i_byte == CH_START) begin
                    s        = '0;
                    s.mode   = MODE_PAYLOAD;
                    o_count  = '0;
                    o_status = ST_FORMAT;
                end else if (i_byte == CH_EOL) begin
                    s.mode   = MODE_WAIT_START;
                    o_status = ST_FORMAT;
                end else if (i_count >= CW'(MAX_LEN - 1)) begin
                    s.mode   = MODE_WAIT_START;
                    o_status = ST_FORMAT;
                end else begin
                    o_count      = i_count + 1'b1;
                    s.xor_acc    = i_state.xor_acc ^ i_byte;
                    te           = i_state.text_ended | (i_byte == CH_NUL);
                    s.text_ended = te;
                    if (!te) begin
                        if (i_state.header < HDR_OK) begin
                            unique case (i_state.header)
                                HDR_NONE: begin
                                    s.header = (i_byte == CH_COMMA) ? HDR_NONE :
                                               (i_byte == CH_D) ? HDR_D : HDR_REJECT;
                                end
                                HDR_D:   s.header = (i_byte == CH_R) ? HDR_DR : HDR_REJECT;
                                HDR_DR:  s.header = (i_byte == CH_V) ? HDR_DRV : HDR_REJECT;
                                default: begin
                                    s.header = (i_byte == CH_COMMA) ? HDR_OK : HDR_REJECT;
                                end
                            endcase
                        end else if (i_state.header == HDR_OK &&
                                     i_state.joints_done < 2'(JOINTS)) begin
                            if (i_byte == CH_COMMA) begin
                                if (i_state.phase != PH_BETWEEN) begin
                                    o_pending[i_state.joints_done] = cur_angle;
                                    s.joints_done = i_state.joints_done + 1'b1;
                                    s.phase       = PH_BETWEEN;
                                    s.negative    = 1'b0;
                                    s.value       = '0;
                                end
                            end else begin
                                ph = (i_state.phase == PH_BETWEEN) ? PH_SPACE : i_state.phase;
                                if (ph == PH_SPACE) begin
                                    if (is_space(i_byte)) begin
                                        ph = PH_SPACE;
                                    end else if (i_byte == CH_MINUS) begin
                                        ph         = PH_IGNORE;
                                        s.negative = 1'b1;
                                        s.phase    = PH_DIGITS;
                                    end else if (i_byte == CH_PLUS) begin
                                        ph      = PH_IGNORE;
                                        s.phase = PH_DIGITS;
                                    end else begin
                                        ph = PH_DIGITS;
                                    end
                                    if (ph != PH_IGNORE) begin
                                        s.phase = ph;
                                    end
                                end
                                if (ph == PH_DIGITS) begin
                                    if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
                                        grown   = 11'({i_state.value, 3'b000}) +
                                                  11'({i_state.value, 1'b0}) +
                                                  11'(i_byte - 8'h30);
                                        s.value = (grown > 11'(ANGLE_MAX)) ? ANGLE_SAT :
                                                  grown[7:0];
                                        s.phase = PH_DIGITS;
                                    end else begin
                                        s.phase = PH_IGNORE;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            MODE_CHECK: begin
                if (!i_state.check_count) begin
                    s.first_nibble = lo;
                    s.check_count  = 1'b1;
                end else begin
                    if (i_state.first_nibble[4] || lo[4]) begin
                        s.first_nibble[4] = 1'b1;
                    end else begin
                        s.xor_acc = i_state.xor_acc ^ {i_state.first_nibble[3:0], lo[3:0]};
                    end
                    s.check_count = 1'b0;
                    s.mode        = MODE_WAIT_EOL;
                end
            end
            default: begin
                s.mode = MODE_WAIT_START;
                if (i_byte != CH_EOL) begin
                    o_status = ST_FORMAT;
                end else if (i_state.first_nibble[4] || i_state.xor_acc != 8'd0) begin
                    o_status = ST_CHECKSUM;
                end else if (i_state.header != HDR_DRV && i_state.header != HDR_OK) begin
                    o_status = ST_FORMAT;
                end else begin
                    for (int i = 0; i < ANGLE_SLOTS; i++) begin
                        if (3'(i) < n_done) begin
                            o_committed[i] = i_pending[i];
                        end
                    end
                    if (i_state.header == HDR_OK && i_state.phase != PH_BETWEEN &&
                        i_state.joints_done < 2'(JOINTS)) begin
                        o_committed[i_state.joints_done] = cur_angle;
                        n_done = n_done + 1'b1;
                    end
                    fin_ok   = (n_done >= 3'(JOINTS));
                    o_status = fin_ok ? ST_SUCCESS : ST_FORMAT;
                end
            end
        endcase
        o_state = s;
    end

endmodule

[rtl/xor_checked_angle_frame_parser.sv]
// Top level of the framed joint-angle parser: input register, handshakes and state.
// Instantiates fcap_step for the per-byte update. Depends on fcap_pkg.
//
//  Port group   Direction  Payload
//  s_axis       in         tdata[7:0] rx_byte
//  m_axis       out        tdata[1:0] status, [9:2] angle_0, [17:10] angle_1,
//                          [25:18] angle_2, [31:26] zero
//
// Each item is held in the input register; the state update then writes its result
// register, from which the result can be taken on the output side.
// One item is taken every cycle while the output side accepts; the sustained rate is set
// by the state register loop around fcap_step. A stalled output holds the result and
// the input register; the input side keeps taking items while that stage is free.
// Synchronous active-low reset clears control state and sets every committed angle to 90.
module xor_checked_angle_frame_parser
    import fcap_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int JOINTS  = JOINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status, angle_0, angle_1, angle_2, zero fill
);

    localparam int CW = $clog2(MAX_LEN);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_out_valid;
    logic [25:0]   r_out_data;
    t_frame_state  r_state;
    logic [CW-1:0] r_count;
    t_angles       r_pending;
    t_angles       r_committed;

    t_frame_state  n_state;
    logic [CW-1:0] n_count;
    t_angles       n_pending;
    t_angles       n_committed;
    logic [1:0]    n_status;
    logic          advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_data};

    fcap_step #(
        .MAX_LEN (MAX_LEN),
        .JOINTS  (JOINTS)
    ) u_step (
        .i_byte      (r_in_byte),
        .i_state     (r_state),
        .i_count     (r_count),
        .i_pending   (r_pending),
        .i_committed (r_committed),
        .o_state     (n_state),
        .o_count     (n_count),
        .o_pending   (n_pending),
        .o_committed (n_committed),
        .o_status    (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_pending  <= n_pending;
            r_out_data <= {n_committed[2], n_committed[1], n_committed[0], n_status};
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_count     <= '0;
            r_committed <= {ANGLE_SLOTS{ANGLE_RESET}};
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_count     <= n_count;
                r_committed <= n_committed;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[sim/frame_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the framed joint-angle parser: watches both item channels,
// predicts each result from the accepted bytes and compares it with the output.
// Depends on fcap_pkg for the character, status, mode, header and phase codes.
module frame_result_checker
    import fcap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // rx_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // status, angle_0, angle_1, angle_2, zero fill
    output int          o_errors,
    output int          o_pending
);

    localparam int PAYLOAD_LIMIT = MAX_LEN_DEF - 1;
    localparam int JOINT_COUNT   = JOINTS_DEF;

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_HEX_A   = 8'h41;
    localparam logic [7:0] CH_HEX_F   = 8'h46;
    localparam logic [7:0] CH_HEX_LA  = 8'h61;
    localparam logic [7:0] CH_HEX_LF  = 8'h66;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] angle_0;
        logic [7:0] angle_1;
        logic [7:0] angle_2;
    } t_parse_result;

    t_parse_result expected_results[$];

    logic [1:0] mode;
    logic [5:0] payload_len;
    logic [7:0] check_acc;
    logic [4:0] first_digit;
    logic       digit_count;
    logic       text_stopped;
    logic [2:0] header_state;
    logic [1:0] joint_count;
    logic [1:0] token_phase;
    logic       token_negative;
    logic [7:0] token_value;
    logic [7:0] pending_angle [ANGLE_SLOTS];
    logic [7:0] committed_angle [ANGLE_SLOTS];

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) return 5'(b - CH_DIGIT_0);
        if (b >= CH_HEX_A && b <= CH_HEX_F) return 5'(b - CH_HEX_A + 8'd10);
        if (b >= CH_HEX_LA && b <= CH_HEX_LF) return 5'(b - CH_HEX_LA + 8'd10);
        return 5'h10;
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [7:0] live_angle();
        if (token_negative) return 8'd0;
        return (token_value > ANGLE_MAX) ? ANGLE_MAX : token_value;
    endfunction

    task automatic clear_frame();
        payload_len    = '0;
        check_acc      = '0;
        first_digit    = '0;
        digit_count    = 1'b0;
        text_stopped   = 1'b0;
        header_state   = HDR_NONE;
        joint_count    = '0;
        token_phase    = PH_BETWEEN;
        token_negative = 1'b0;
        token_value    = '0;
    endtask

    task automatic header_step(input logic [7:0] b);
        case (header_state)
            HDR_NONE: header_state = (b == CH_COMMA) ? HDR_NONE :
                                     (b == CH_D) ? HDR_D : HDR_REJECT;
            HDR_D:    header_state = (b == CH_R) ? HDR_DR : HDR_REJECT;
            HDR_DR:   header_state = (b == CH_V) ? HDR_DRV : HDR_REJECT;
            HDR_DRV:  header_state = (b == CH_COMMA) ? HDR_OK : HDR_REJECT;
            default:  ;
        endcase
    endtask

    task automatic joint_step(input logic [7:0] b);
        int grown;
        if (joint_count >= JOINT_COUNT) return;
        if (b == CH_COMMA) begin
            if (token_phase != PH_BETWEEN) begin
                pending_angle[joint_count] = live_angle();
                joint_count    = joint_count + 2'd1;
                token_phase    = PH_BETWEEN;
                token_negative = 1'b0;
                token_value    = '0;
            end
            return;
        end
        if (token_phase == PH_BETWEEN) token_phase = PH_SPACE;
        if (token_phase == PH_SPACE) begin
            if (blank(b)) return;
            token_phase = PH_DIGITS;
            if (b == CH_MINUS) begin
                token_negative = 1'b1;
                return;
            end
            if (b == CH_PLUS) return;
        end
        if (token_phase == PH_DIGITS) begin
            if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
                grown = int'(token_value) * 10 + int'(b - CH_DIGIT_0);
                token_value = (grown > int'(ANGLE_MAX)) ? ANGLE_SAT : 8'(grown);
            end else begin
                token_phase = PH_IGNORE;
            end
        end
    endtask

    task automatic close_frame(output logic [1:0] st);
        int n;
        if (first_digit[4] || check_acc != 8'd0) begin
            st = ST_CHECKSUM;
            return;
        end
        if (header_state != HDR_DRV && header_state != HDR_OK) begin
            st = ST_FORMAT;
            return;
        end
        n = joint_count;
        for (int i = 0; i < n && i < ANGLE_SLOTS; i++) committed_angle[i] = pending_angle[i];
        if (header_state == HDR_OK && token_phase != PH_BETWEEN && n < JOINT_COUNT) begin
            committed_angle[n] = live_angle();
            n++;
        end
        st = (n >= JOINT_COUNT) ? ST_SUCCESS : ST_FORMAT;
    endtask

    task automatic absorb_byte(input logic [7:0] b, output logic [1:0] st);
        logic [4:0] low_digit;
        st = ST_IN_PROGRESS;
        case (mode)
            MODE_WAIT_START: begin
                if (b == CH_START) begin
                    clear_frame();
                    mode = MODE_PAYLOAD;
                end
            end
            MODE_PAYLOAD: begin
                if (b == CH_STAR) begin
                    digit_count = 1'b0;
                    mode = MODE_CHECK;
                end else if (b == CH_START) begin
                    clear_frame();
                    st = ST_FORMAT;
                end else if (b == CH_EOL) begin
                    mode = MODE_WAIT_START;
                    st = ST_FORMAT;
                end else if (payload_len >= PAYLOAD_LIMIT) begin
                    mode = MODE_WAIT_START;
                    st = ST_FORMAT;
                end else begin
                    payload_len = payload_len + 6'd1;
                    check_acc = check_acc ^ b;
                    if (b == CH_NUL) text_stopped = 1'b1;
                    if (!text_stopped) begin
                        if (header_state < HDR_OK) header_step(b);
                        else if (header_state == HDR_OK) joint_step(b);
                    end
                end
            end
            MODE_CHECK: begin
                if (!digit_count) begin
                    first_digit = hex_value(b);
                    digit_count = 1'b1;
                end else begin
                    low_digit = hex_value(b);
                    if (first_digit[4] || low_digit[4]) first_digit[4] = 1'b1;
                    else check_acc = check_acc ^ {first_digit[3:0], low_digit[3:0]};
                    digit_count = 1'b0;
                    mode = MODE_WAIT_EOL;
                end
            end
            default: begin
                mode = MODE_WAIT_START;
                if (b != CH_EOL) st = ST_FORMAT;
                else close_frame(st);
            end
        endcase
    endtask

    function automatic int differs(input string what, input int want, input int got);
        if (want == got) return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_parse_result seen;
        t_parse_result want;
        logic [1:0] st;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            clear_frame();
            mode = MODE_WAIT_START;
            for (int i = 0; i < ANGLE_SLOTS; i++) begin
                pending_angle[i]   = 8'd0;
                committed_angle[i] = ANGLE_RESET;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.status  = i_out_data[1:0];
                seen.angle_0 = i_out_data[9:2];
                seen.angle_1 = i_out_data[17:10];
                seen.angle_2 = i_out_data[25:18];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_data);
                    bad++;
                end else begin
                    want = expected_results.pop_front();
                    bad += differs("status", want.status, seen.status);
                    bad += differs("angle_0", want.angle_0, seen.angle_0);
                    bad += differs("angle_1", want.angle_1, seen.angle_1);
                    bad += differs("angle_2", want.angle_2, seen.angle_2);
                    bad += differs("zero fill", 0, i_out_data[31:26]);
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_byte(i_in_data, st);
                expected_results.push_back({st, committed_angle[0], committed_angle[1],
                                            committed_angle[2]});
            end
        end
        o_errors  <= o_errors + bad;
        o_pending <= expected_results.size();
    end

endmodule

[sim/xor_checked_angle_frame_parser_test.sv]
`timescale 1ns / 100ps
// Top of the framed joint-angle parser testbench: clock, reset, byte stimulus,
// output back-pressure, watchdog and verdict. Depends on fcap_pkg, the parser
// and frame_result_checker.
module xor_checked_angle_frame_parser_test;
    import fcap_pkg::*;

    localparam int END_GOOD    = 0;
    localparam int END_BAD_SUM = 1;
    localparam int END_NOT_HEX = 2;
    localparam int END_TAIL    = 3;

    localparam int RANDOM_BYTES = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_HEX_A   = 8'h41;
    localparam logic [7:0] CH_HEX_LA  = 8'h61;
    localparam logic [7:0] CH_FILL    = 8'h5F;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;

    int  check_errors;
    int  check_pending;
    int  sent_count = 0;
    bit  calm = 1'b0;
    bit  held = 1'b0;

    logic [7:0] stream_bytes[$];
    logic [7:0] body[$];

    always #6 i_clk = ~i_clk;

    xor_checked_angle_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    frame_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (check_errors),
        .o_pending   (check_pending)
    );

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return CH_DIGIT_0 + 8'(n);
        return (lower ? CH_HEX_LA : CH_HEX_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_STAR || b == CH_START || b == CH_EOL) b = CH_FILL;
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(4))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0B;
            3: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    endtask

    task automatic push_raw(input string s);
        for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
    endtask

    task automatic put_separator();
        int extra;
        extra = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (1 + extra) body.push_back(CH_COMMA);
    endtask

    task automatic put_number();
        int r;
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) body.push_back(blank_byte());
        r = $urandom_range(9);
        if (r == 0) body.push_back(CH_MINUS);
        else if (r == 1) body.push_back(CH_PLUS);
        r = $urandom_range(9);
        if (r == 1) put($sformatf("%0d", $urandom_range(181, 999999)));
        else if (r == 2) put($sformatf("00%0d", $urandom_range(0, 180)));
        else if (r != 0) put($sformatf("%0d", $urandom_range(0, 180)));
        if ($urandom_range(9) == 0) body.push_back(plain_byte());
    endtask

    task automatic seal_frame(input int ending);
        logic [7:0] sum;
        logic [7:0] odd;
        string      odd_set;
        bit         lower;
        sum = 8'h00;
        lower = $urandom_range(1);
        foreach (body[i]) sum ^= body[i];
        stream_bytes.push_back(CH_START);
        foreach (body[i]) stream_bytes.push_back(body[i]);
        stream_bytes.push_back(CH_STAR);
        if (ending == END_BAD_SUM) sum ^= 8'(1 << $urandom_range(7));
        if (ending == END_NOT_HEX) begin
            odd_set = "gxZ @\n";
            odd = odd_set[$urandom_range(odd_set.len() - 1)];
            if ($urandom_range(1)) begin
                stream_bytes.push_back(odd);
                stream_bytes.push_back(hex_char(sum[3:0], lower));
            end else begin
                stream_bytes.push_back(hex_char(sum[7:4], lower));
                stream_bytes.push_back(odd);
            end
        end else begin
            stream_bytes.push_back(hex_char(sum[7:4], lower));
            stream_bytes.push_back(hex_char(sum[3:0], lower));
        end
        if (ending == END_TAIL) begin
            odd_set = "Z\r @";
            stream_bytes.push_back(odd_set[$urandom_range(odd_set.len() - 1)]);
        end else begin
            stream_bytes.push_back(CH_EOL);
        end
        body.delete();
    endtask

    task automatic random_frame();
        int r;
        int joints;
        int e;
        r = $urandom_range(99);
        if (r < 72) begin
            if ($urandom_range(9) == 0) body.push_back(CH_COMMA);
            put("DRV");
            joints = ($urandom_range(9) < 7) ? 3 : $urandom_range(0, 5);
            for (int j = 0; j < joints; j++) begin
                put_separator();
                put_number();
            end
            if ($urandom_range(7) == 0) body.push_back(CH_COMMA);
            if ($urandom_range(14) == 0) begin
                body.push_back(CH_NUL);
                put(",9");
            end
            e = $urandom_range(19);
            seal_frame(e < 16 ? END_GOOD : e == 16 ? END_BAD_SUM :
                       e == 17 ? END_NOT_HEX : END_TAIL);
        end else if (r < 80) begin
            case ($urandom_range(5))
                0: put("DRX");
                1: put("DR");
                2: put("drv");
                3: put("XDRV");
                4: put("DRVV");
                default: ;
            endcase
            if ($urandom_range(3) != 0) begin
                repeat (3) begin
                    put_separator();
                    put_number();
                end
            end
            seal_frame(END_GOOD);
        end else if (r < 86) begin
            push_raw($sformatf("@DRV,%0d", $urandom_range(180)));
            put($sformatf("DRV,%0d,%0d,%0d", $urandom_range(180), $urandom_range(180),
                          $urandom_range(180)));
            seal_frame(END_GOOD);
        end else if (r < 90) begin
            push_raw($sformatf("@DRV,%0d\n", $urandom_range(180)));
        end else if (r < 92) begin
            put("DRV,1,2,3,");
            repeat ($urandom_range(55, 70)) body.push_back(plain_byte());
            seal_frame(END_GOOD);
        end else begin
            repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= 120) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin : sender
        int directed_len;
        int gap;
        put("DRV,0,180,90");
        seal_frame(END_GOOD);
        put("DRV,,, 45,+12,-7");
        seal_frame(END_GOOD);
        put("DRV,99999,abc,200");
        seal_frame(END_GOOD);
        put("DRV,10");
        seal_frame(END_GOOD);
        put("DRV,1,2,3,4,5");
        seal_frame(END_GOOD);
        put("DRV,5,6");
        body.push_back(CH_NUL);
        put(",7");
        seal_frame(END_GOOD);
        put("DRV,30,60,120");
        seal_frame(END_BAD_SUM);
        put("DRV,30,60,120");
        seal_frame(END_NOT_HEX);
        put("XYZ,1,2,3");
        seal_frame(END_GOOD);
        push_raw("@DRV,1");
        put("DRV,2,3,4");
        seal_frame(END_GOOD);
        push_raw("@DRV\n");
        push_raw("@DRV,1,2,3*\n@\n");
        put("DRV,7,8,9");
        seal_frame(END_TAIL);
        put("DRV");
        seal_frame(END_GOOD);
        put("DRV,");
        repeat (70) body.push_back(plain_byte());
        seal_frame(END_GOOD);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h00);
        directed_len = stream_bytes.size();
        while (stream_bytes.size() < directed_len + RANDOM_BYTES) random_frame();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int idx = 0; idx < stream_bytes.size(); idx++) begin
            calm = (idx >= directed_len + 20) && (idx < directed_len + 100);
            gap = 0;
            if (!calm) while ($urandom_range(99) < 12) gap++;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stream_bytes[idx];
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            sent_count = idx + 1;
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        @(posedge i_clk);
        while (check_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (check_errors == 0 && check_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
